/* hdl/fftr_pkg.sv */
// Shared types and codes of the file transfer packet receiver.
// No dependencies; the parser, the skid stage and the top module import this package.
package fftr_pkg;

  // Parse phase of the current packet
  typedef enum logic [3:0] {
    PH_TYPE,
    PH_TAG0,
    PH_SLEN,
    PH_SVAL,
    PH_TAG1,
    PH_NLEN,
    PH_NAME,
    PH_SEQ,
    PH_LHI,
    PH_LLO,
    PH_DATA,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  // Verdict codes given at the end of a packet
  typedef enum logic [2:0] {
    V_OK,
    V_IGNORED,
    V_TAG,
    V_TRUNC,
    V_SEQ,
    V_SIZE,
    V_NAME
  } verdict_t;

  // Packet types as carried in the first byte
  typedef enum logic [1:0] {
    PT_NONE,
    PT_START,
    PT_DATA,
    PT_END
  } ptype_t;

  // TLV tags of start and end packets
  localparam logic [7:0] TAG_SIZE = 8'd0;
  localparam logic [7:0] TAG_NAME = 8'd1;

  // Result kinds
  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_VERDICT = 1'b1;

  // One result item
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [1:0]  packet_type;
    logic [63:0] file_size;
    logic [15:0] payload_length;
    logic [7:0]  sequence_seen;
  } res_t;

endpackage

/* hdl/fftr_in_if.sv */
// Input channel of the packet receiver: one packet byte per request.
// No dependencies.
interface fftr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, rx_byte, end_of_packet, input ready);
  modport sink   (input valid, rx_byte, end_of_packet, output ready);
endinterface

/* hdl/fftr_out_if.sv */
// Result channel of the packet receiver: payload bytes and verdicts.
// No dependencies.
interface fftr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  verdict;
  logic [1:0]  packet_type;
  logic [63:0] file_size;
  logic [15:0] payload_length;
  logic [7:0]  sequence_seen;

  modport source (output valid, result_kind, payload_byte, verdict, packet_type,
                  file_size, payload_length, sequence_seen, input ready);
  modport sink   (input valid, result_kind, payload_byte, verdict, packet_type,
                  file_size, payload_length, sequence_seen, output ready);
endinterface

/* hdl/fftr_parser.sv */
// Packet parser: phase state, stored size and name, name memory, result build.
// Depends on fftr_pkg.
module fftr_parser #(
  parameter int NAME_DEPTH     = 256,
  parameter int SIZE_BYTES_MAX = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_packet,
  output logic          res_valid,
  output fftr_pkg::res_t res
);
  import fftr_pkg::*;

  localparam int AW = $clog2(NAME_DEPTH);

  phase_t       phase_r, phase_stp, phase_nxt;
  ptype_t       type_r, type_nxt;
  logic [15:0]  pos_r, pos_nxt, pos_inc;
  logic [7:0]   slen_r, slen_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic [7:0]   nlen_r, nlen_nxt;
  logic [63:0]  ssize_r, ssize_nxt;
  logic [7:0]   snlen_r, snlen_nxt;
  logic [7:0]   expseq_r, expseq_nxt;
  logic [15:0]  dlen_r, dlen_nxt;
  verdict_t     err_r, err_stp, err_nxt;
  logic [7:0]   seqseen_r, seqseen_nxt;
  logic         payload;
  logic         size_fin;
  logic         wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]   name_mem [NAME_DEPTH];
  logic [7:0]   name_rd_r;

  assign pos_inc = pos_r + 16'd1;

  // Next state
  always_comb begin
    phase_stp   = phase_r;
    type_nxt    = type_r;
    pos_nxt     = pos_r;
    slen_nxt    = slen_r;
    acc_nxt     = acc_r;
    nlen_nxt    = nlen_r;
    ssize_nxt   = ssize_r;
    snlen_nxt   = snlen_r;
    dlen_nxt    = dlen_r;
    err_stp     = err_r;
    seqseen_nxt = seqseen_r;
    payload     = 1'b0;
    size_fin    = 1'b0;
    wr_en       = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_TYPE: begin
          acc_nxt     = '0;
          dlen_nxt    = '0;
          seqseen_nxt = '0;
          pos_nxt     = '0;
          err_stp     = V_OK;
          if (rx_byte == {6'd0, PT_START} || rx_byte == {6'd0, PT_END}) begin
            type_nxt  = ptype_t'(rx_byte[1:0]);
            phase_stp = PH_TAG0;
          end else if (rx_byte == {6'd0, PT_DATA}) begin
            type_nxt  = PT_DATA;
            phase_stp = PH_SEQ;
          end else begin
            type_nxt  = PT_NONE;
            err_stp   = V_IGNORED;
            phase_stp = PH_SKIP;
          end
        end
        PH_TAG0: begin
          if (rx_byte != TAG_SIZE) begin
            err_stp   = V_TAG;
            phase_stp = PH_SKIP;
          end else begin
            phase_stp = PH_SLEN;
          end
        end
        PH_SLEN: begin
          slen_nxt = rx_byte;
          pos_nxt  = '0;
          if (rx_byte == 8'd0) size_fin = 1'b1;
          else phase_stp = PH_SVAL;
        end
        PH_SVAL: begin
          // Bytes past the size limit are read but dropped
          for (int k = 0; k < SIZE_BYTES_MAX; k++) begin
            if (pos_r == 16'(k)) acc_nxt[8*k +: 8] = acc_r[8*k +: 8] | rx_byte;
          end
          pos_nxt = pos_inc;
          if (pos_inc >= {8'd0, slen_r}) size_fin = 1'b1;
        end
        PH_TAG1: begin
          if (rx_byte != TAG_NAME) begin
            err_stp   = V_TAG;
            phase_stp = PH_SKIP;
          end else begin
            phase_stp = PH_NLEN;
          end
        end
        PH_NLEN: begin
          nlen_nxt = rx_byte;
          pos_nxt  = '0;
          if (type_r == PT_START && {24'd0, rx_byte} >= 32'(NAME_DEPTH)) begin
            err_stp   = V_TAG;
            phase_stp = PH_SKIP;
          end else if (type_r != PT_START && rx_byte != snlen_r) begin
            err_stp   = V_NAME;
            phase_stp = PH_SKIP;
          end else begin
            if (type_r == PT_START) snlen_nxt = rx_byte;
            phase_stp = (rx_byte == 8'd0) ? PH_TAIL : PH_NAME;
          end
        end
        PH_NAME: begin
          if (type_r != PT_START && {16'd0, pos_r} < 32'(NAME_DEPTH) &&
              name_rd_r != rx_byte) begin
            err_stp   = V_NAME;
            phase_stp = PH_SKIP;
          end else begin
            wr_en   = (type_r == PT_START) && ({16'd0, pos_r} < 32'(NAME_DEPTH));
            pos_nxt = pos_inc;
            if (pos_inc >= {8'd0, nlen_r}) phase_stp = PH_TAIL;
          end
        end
        PH_SEQ: begin
          seqseen_nxt = rx_byte;
          if (rx_byte != expseq_r) begin
            err_stp   = V_SEQ;
            phase_stp = PH_SKIP;
          end else begin
            phase_stp = PH_LHI;
          end
        end
        PH_LHI: begin
          dlen_nxt  = {rx_byte, 8'd0};
          phase_stp = PH_LLO;
        end
        PH_LLO: begin
          dlen_nxt  = {dlen_r[15:8], rx_byte};
          pos_nxt   = '0;
          phase_stp = ({dlen_r[15:8], rx_byte} == 16'd0) ? PH_TAIL : PH_DATA;
        end
        PH_DATA: begin
          payload = 1'b1;
          pos_nxt = pos_inc;
          if (pos_inc >= dlen_r) phase_stp = PH_TAIL;
        end
        default: ;
      endcase
      // Size field complete: store on start, check on end
      if (size_fin) begin
        if (type_r == PT_START) begin
          ssize_nxt = acc_nxt;
          phase_stp = PH_TAG1;
        end else if (acc_nxt != ssize_r) begin
          err_stp   = V_SIZE;
          phase_stp = PH_SKIP;
        end else begin
          phase_stp = PH_TAG1;
        end
      end
    end
  end

  // Packet end: rearm for the next type byte, advance sequence after data
  always_comb begin
    phase_nxt  = phase_stp;
    err_nxt    = err_stp;
    expseq_nxt = expseq_r;
    if (in_fire && end_of_packet) begin
      phase_nxt = PH_TYPE;
      err_nxt   = V_OK;
      if (type_nxt == PT_DATA) expseq_nxt = expseq_r + 8'd1;
    end
  end

  // Result build
  always_comb begin
    res_valid          = in_fire && (end_of_packet || payload);
    res.result_kind    = end_of_packet ? RK_VERDICT : RK_PAYLOAD;
    res.payload_byte   = payload ? rx_byte : 8'd0;
    res.packet_type    = type_nxt;
    res.file_size      = (type_nxt == PT_START || type_nxt == PT_END) ? acc_nxt : 64'd0;
    res.payload_length = (type_nxt == PT_DATA) ? dlen_nxt : 16'd0;
    res.sequence_seen  = (type_nxt == PT_DATA) ? seqseen_nxt : 8'd0;
    if (!end_of_packet)          res.verdict = V_OK;
    else if (err_stp != V_OK)    res.verdict = err_stp;
    else if (phase_stp == PH_TAIL) res.verdict = V_OK;
    else                         res.verdict = V_TRUNC;
  end

  // Read one step ahead so the entry for the current name position is ready
  assign rd_addr = in_fire ? pos_nxt[AW-1:0] : pos_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) name_mem[pos_r[AW-1:0]] <= rx_byte;
    name_rd_r <= name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      type_r    <= PT_NONE;
      pos_r     <= '0;
      slen_r    <= '0;
      acc_r     <= '0;
      nlen_r    <= '0;
      ssize_r   <= '0;
      snlen_r   <= '0;
      expseq_r  <= '0;
      dlen_r    <= '0;
      err_r     <= V_OK;
      seqseen_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      pos_r     <= pos_nxt;
      slen_r    <= slen_nxt;
      acc_r     <= acc_nxt;
      nlen_r    <= nlen_nxt;
      ssize_r   <= ssize_nxt;
      snlen_r   <= snlen_nxt;
      expseq_r  <= expseq_nxt;
      dlen_r    <= dlen_nxt;
      err_r     <= err_nxt;
      seqseen_r <= seqseen_nxt;
    end
  end

endmodule

/* hdl/fftr_skid.sv */
// Result register with a skid stage behind it.
// Depends on fftr_pkg.
module fftr_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fftr_pkg::res_t push_data,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output fftr_pkg::res_t out_data
);
  import fftr_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;
  logic main_free;

  assign pop       = main_v_r && out_ready;
  assign main_free = !main_v_r || pop;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (main_free) begin
      if (skid_v_r) begin
        // advance the held request, park a new one behind it
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

endmodule

/* hdl/file_transfer_packet_receiver.sv */
// Receiver for a small file transfer protocol carried in link-layer packets.
// Depends on fftr_pkg, fftr_in_if, fftr_out_if, fftr_parser and fftr_skid.
//
// Use: feed packet bytes on in_chan, one byte per request, with
// end_of_packet high on the last byte. Byte 0 selects start (1), data (2)
// or end (3); other types are ignored. Start packets store the file size
// and name; end packets are checked against them; data packets check the
// sequence number and pass payload bytes out.
// out_chan carries a payload request for each passed payload byte and a
// verdict request on the last byte of every packet; a byte brings at most
// one request.
// Each request is built combinationally from the accepted byte and registered in
// the result register, or in the skid stage while the output stalls.
// Throughput: one byte per cycle while the skid stage is empty, set by the single
// parse step between the phase registers and the result register; the name memory
// is read one position ahead so the compare never waits.
// Reset (synchronous, rst_n low): parse restarts at the type byte, stored
// size, name length and expected sequence clear to zero, output is empty.
// The name memory keeps its contents and needs no clearing pass.
// Stall: when out_chan.ready is low the result register holds and a skid
// stage takes one more request; in_chan.ready drops only when both are full.
module file_transfer_packet_receiver #(
  parameter int NAME_DEPTH     = 256,
  parameter int SIZE_BYTES_MAX = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  fftr_in_if.sink           in_chan,
  fftr_out_if.source        out_chan
);
  import fftr_pkg::*;

  logic in_fire;
  logic res_valid;
  logic can_push;
  res_t res;
  res_t out_data;

  // Accept a byte whenever the skid stage is empty
  assign in_chan.ready = can_push;
  assign in_fire       = in_chan.valid && can_push;

  fftr_parser #(
    .NAME_DEPTH     (NAME_DEPTH),
    .SIZE_BYTES_MAX (SIZE_BYTES_MAX)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .rx_byte       (in_chan.rx_byte),
    .end_of_packet (in_chan.end_of_packet),
    .res_valid     (res_valid),
    .res           (res)
  );

  fftr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  // Drive the result channel fields from the result register
  assign out_chan.result_kind    = out_data.result_kind;
  assign out_chan.payload_byte   = out_data.payload_byte;
  assign out_chan.verdict        = out_data.verdict;
  assign out_chan.packet_type    = out_data.packet_type;
  assign out_chan.file_size      = out_data.file_size;
  assign out_chan.payload_length = out_data.payload_length;
  assign out_chan.sequence_seen  = out_data.sequence_seen;

  // An accepted last byte always leaves a request waiting on the output
  a_eop_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_packet |=> out_chan.valid)
    else $error("no result after end of packet");

  // Payload requests only come from clean data packets
  a_payload_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.result_kind == RK_PAYLOAD |->
      out_chan.packet_type == PT_DATA && out_chan.verdict == V_OK)
    else $error("payload request outside a good data packet");

  // Data-only fields stay zero for other packet types
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.packet_type != PT_DATA |->
      out_chan.payload_length == 16'd0 && out_chan.sequence_seen == 8'd0)
    else $error("data fields set for a non-data packet");

endmodule
